FILE: design/pidpc_pkg.sv
// Shared types and constants for the PID position controller.
`default_nettype none
package pidpc_pkg;

    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned ILIM_W   = 23;
    localparam int unsigned CLIM_W   = 12;
    localparam int unsigned ANGLE_W  = 24;
    localparam int unsigned ERR_W    = 25;
    localparam int unsigned INTEG_W  = 24;
    localparam int unsigned DIFF_W   = 26;
    localparam int unsigned CMD_W    = 13;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd11796480;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd6554;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd458752000;
    localparam logic [ILIM_W-1:0] INTEG_LIM_RST  = 23'd128000;
    localparam logic [CLIM_W-1:0] CURR_LIM_RST   = 12'd700;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEG_GAIN    = 3'd1,
        CFG_DERIV_GAIN    = 3'd2,
        CFG_INTEG_LIMIT   = 3'd3,
        CFG_CURRENT_LIMIT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [ILIM_W-1:0] integ_limit;
        logic [CLIM_W-1:0] current_limit;
    } t_cfg;

endpackage
`default_nettype wire

FILE: design/pidpc_cfg_regs.sv
// Configuration register file for the PID position controller.
`default_nettype none
module pidpc_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [pidpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pidpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pidpc_pkg::t_cfg                         o_cfg
);

    pidpc_pkg::t_cfg r_cfg;
    pidpc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pidpc_pkg::CFG_PROP_GAIN:     n_cfg.prop_gain     = i_cfg_data;
                pidpc_pkg::CFG_INTEG_GAIN:    n_cfg.integ_gain    = i_cfg_data;
                pidpc_pkg::CFG_DERIV_GAIN:    n_cfg.deriv_gain    = i_cfg_data;
                pidpc_pkg::CFG_INTEG_LIMIT:
                    n_cfg.integ_limit   = i_cfg_data[pidpc_pkg::ILIM_W-1:0];
                pidpc_pkg::CFG_CURRENT_LIMIT:
                    n_cfg.current_limit = i_cfg_data[pidpc_pkg::CLIM_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= pidpc_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain    <= pidpc_pkg::INTEG_GAIN_RST;
            r_cfg.deriv_gain    <= pidpc_pkg::DERIV_GAIN_RST;
            r_cfg.integ_limit   <= pidpc_pkg::INTEG_LIM_RST;
            r_cfg.current_limit <= pidpc_pkg::CURR_LIM_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

FILE: design/pid_position_controller_unit.sv
// PID position controller: error, clamped integral, three gain products, shift and saturation.
// An accepted request passes the stage 1, 2 and 3 registers before its result is valid.
// Throughput: one request per cycle unless the output stalls; three stages (error/integral,
// products, sum/clamp). Integral and previous error update as a request is accepted, so
// requests may follow back to back.
// Synchronous active-low reset clears integral, previous error, pipeline valids and
// restores default gains and limits.
`default_nettype none
module pid_position_controller_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [pidpc_pkg::ANGLE_W-1:0] i_target_angle,
    input  wire logic signed [pidpc_pkg::ANGLE_W-1:0] i_measured_angle,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [pidpc_pkg::CMD_W-1:0]        o_current_command,
    output logic                                      o_saturated,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [pidpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pidpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned PP_W  = pidpc_pkg::GAIN_W + 1 + pidpc_pkg::ERR_W;
    localparam int unsigned PI_W  = pidpc_pkg::GAIN_W + 1 + pidpc_pkg::INTEG_W;
    localparam int unsigned PD_W  = pidpc_pkg::GAIN_W + 1 + pidpc_pkg::DIFF_W;
    localparam int unsigned SUM_W = PD_W + 1;
    localparam int unsigned SHIFT = 24;
    localparam int unsigned RAW_W = SUM_W - SHIFT;
    localparam int unsigned ACC_W = pidpc_pkg::ERR_W + 1;

    pidpc_pkg::t_cfg cfg;

    pidpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline control
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3, accept;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // stage 1: error, clamped integral, error difference
    logic signed [pidpc_pkg::ERR_W-1:0]   n_err;
    logic signed [ACC_W-1:0]              acc_sum;
    logic signed [ACC_W-1:0]              ilim_pos;
    logic signed [ACC_W-1:0]              ilim_neg;
    logic signed [pidpc_pkg::INTEG_W-1:0] n_integ;
    logic signed [pidpc_pkg::DIFF_W-1:0]  n_diff;

    logic signed [pidpc_pkg::INTEG_W-1:0] r_integ;
    logic signed [pidpc_pkg::ERR_W-1:0]   r_prev;
    logic signed [pidpc_pkg::ERR_W-1:0]   r_err;
    logic signed [pidpc_pkg::INTEG_W-1:0] r_integ_s1;
    logic signed [pidpc_pkg::DIFF_W-1:0]  r_diff;

    always_comb begin
        n_err    = {i_target_angle[pidpc_pkg::ANGLE_W-1], i_target_angle}
                 - {i_measured_angle[pidpc_pkg::ANGLE_W-1], i_measured_angle};
        acc_sum  = {{(ACC_W-pidpc_pkg::INTEG_W){r_integ[pidpc_pkg::INTEG_W-1]}}, r_integ}
                 + {n_err[pidpc_pkg::ERR_W-1], n_err};
        ilim_pos = $signed({{(ACC_W-pidpc_pkg::ILIM_W){1'b0}}, cfg.integ_limit});
        ilim_neg = -ilim_pos;
        priority if (acc_sum > ilim_pos) begin
            n_integ = ilim_pos[pidpc_pkg::INTEG_W-1:0];
        end else if (acc_sum < ilim_neg) begin
            n_integ = ilim_neg[pidpc_pkg::INTEG_W-1:0];
        end else begin
            n_integ = acc_sum[pidpc_pkg::INTEG_W-1:0];
        end
        n_diff = {n_err[pidpc_pkg::ERR_W-1], n_err} - {r_prev[pidpc_pkg::ERR_W-1], r_prev};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (accept) begin
            r_integ <= n_integ;
            r_prev  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_err      <= n_err;
            r_integ_s1 <= n_integ;
            r_diff     <= n_diff;
        end
    end

    // stage 2: gain products
    logic signed [PP_W-1:0] r_pp;
    logic signed [PI_W-1:0] r_pi;
    logic signed [PD_W-1:0] r_pd;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_pp <= $signed({1'b0, cfg.prop_gain})  * r_err;
            r_pi <= $signed({1'b0, cfg.integ_gain}) * r_integ_s1;
            r_pd <= $signed({1'b0, cfg.deriv_gain}) * r_diff;
        end
    end

    // stage 3: sum, floor shift, saturate
    logic signed [SUM_W-1:0] sum;
    logic signed [RAW_W-1:0] raw;
    logic signed [RAW_W-1:0] clim_pos;
    logic signed [RAW_W-1:0] clim_neg;
    logic signed [pidpc_pkg::CMD_W-1:0] n_cmd;
    logic n_sat;
    logic signed [pidpc_pkg::CMD_W-1:0] r_cmd;
    logic r_sat;

    always_comb begin
        sum = {{(SUM_W-PP_W){r_pp[PP_W-1]}}, r_pp}
            + {{(SUM_W-PI_W){r_pi[PI_W-1]}}, r_pi}
            + {{(SUM_W-PD_W){r_pd[PD_W-1]}}, r_pd};
        raw      = sum[SUM_W-1:SHIFT];
        clim_pos = $signed({{(RAW_W-pidpc_pkg::CLIM_W){1'b0}}, cfg.current_limit});
        clim_neg = -clim_pos;
        priority if (raw > clim_pos) begin
            n_cmd = clim_pos[pidpc_pkg::CMD_W-1:0];
            n_sat = 1'b1;
        end else if (raw < clim_neg) begin
            n_cmd = clim_neg[pidpc_pkg::CMD_W-1:0];
            n_sat = 1'b1;
        end else begin
            n_cmd = raw[pidpc_pkg::CMD_W-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_cmd <= n_cmd;
            r_sat <= n_sat;
        end
    end

    assign o_valid           = r_v3;
    assign o_current_command = r_cmd;
    assign o_saturated       = r_sat;

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted request not captured in first stage");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !i_ready) |-> !o_ready)
        else $error("request taken while pipeline full and stalled");

    a_prev_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_prev == $past(
            {i_target_angle[pidpc_pkg::ANGLE_W-1], i_target_angle}
            - {i_measured_angle[pidpc_pkg::ANGLE_W-1], i_measured_angle}))
        else $error("previous error not updated from accepted request");

endmodule
`default_nettype wire
